>>> hdl/lwrf_pkg.sv
// package for the lcd window rectangle fill sequencer
// transaction payload types, sequencer phase codes and panel command bytes; no dependencies

package lwrf_pkg;

  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_COL_CMD  = 4'd1,
    PH_COL_SH   = 4'd2,
    PH_COL_SL   = 4'd3,
    PH_COL_EH   = 4'd4,
    PH_COL_EL   = 4'd5,
    PH_PAGE_CMD = 4'd6,
    PH_PAGE_SH  = 4'd7,
    PH_PAGE_SL  = 4'd8,
    PH_PAGE_EH  = 4'd9,
    PH_PAGE_EL  = 4'd10,
    PH_MEM_WR   = 4'd11,
    PH_PIXELS   = 4'd12
  } phase_t;

  localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
  localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE  = 8'h2C;

  typedef struct packed {
    op_t         operation;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] rect_width;
    logic [15:0] rect_height;
    logic [15:0] color;
  } lwrf_in_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       is_data;
    logic       release_select;
    logic       last;
  } lwrf_out_t;

endpackage

>>> hdl/lwrf_seq.sv
// byte sequencer: rectangle clipping, window state and the next serial byte
// depends on lwrf_pkg

module lwrf_seq #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 240
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  lwrf_pkg::lwrf_in_t step_item,
  output logic               res_valid,
  output lwrf_pkg::lwrf_out_t res
);
  import lwrf_pkg::*;

  localparam int CW_W  = $clog2(PANEL_WIDTH + 1);
  localparam int RW_W  = $clog2(PANEL_HEIGHT + 1);
  localparam int BR_W  = $clog2(2 * PANEL_WIDTH);
  localparam int CMP_W = CW_W + 1;
  localparam logic [15:0] PW16 = 16'(PANEL_WIDTH);
  localparam logic [15:0] PH16 = 16'(PANEL_HEIGHT);

  phase_t            phase_r, phase_nxt;
  logic [15:0]       column_first_r, column_first_nxt;
  logic [15:0]       column_last_r, column_last_nxt;
  logic [15:0]       page_first_r, page_first_nxt;
  logic [15:0]       page_last_r, page_last_nxt;
  logic [15:0]       fill_value_r, fill_value_nxt;
  logic [CW_W-1:0]   clipped_width_r, clipped_width_nxt;
  logic [BR_W-1:0]   byte_in_row_r, byte_in_row_nxt;
  logic [RW_W-1:0]   rows_left_r, rows_left_nxt;

  logic [16:0]       x_sum, y_sum;
  logic [15:0]       w_clip, h_clip;
  logic              in_panel;
  logic [7:0]        pix_byte;
  logic              row_end;
  logic [RW_W-1:0]   rows_dec;
  logic              empty;

  // start item clipping
  always_comb begin
    x_sum    = {1'b0, step_item.x_start} + {1'b0, step_item.rect_width};
    y_sum    = {1'b0, step_item.y_start} + {1'b0, step_item.rect_height};
    in_panel = (step_item.x_start < PW16) && (step_item.y_start < PH16);
    w_clip   = (x_sum > {1'b0, PW16}) ? (PW16 - step_item.x_start) : step_item.rect_width;
    h_clip   = (y_sum > {1'b0, PH16}) ? (PH16 - step_item.y_start) : step_item.rect_height;
  end

  // pixel stream helpers
  always_comb begin
    pix_byte = byte_in_row_r[0] ? fill_value_r[7:0] : fill_value_r[15:8];
    row_end  = (CMP_W'(byte_in_row_r) + CMP_W'(1)) >= {clipped_width_r, 1'b0};
    rows_dec = (rows_left_r == '0) ? '0 : rows_left_r - RW_W'(1);
    empty    = (clipped_width_r == '0) || (rows_left_r == '0);
  end

  always_comb begin
    phase_nxt         = phase_r;
    column_first_nxt  = column_first_r;
    column_last_nxt   = column_last_r;
    page_first_nxt    = page_first_r;
    page_last_nxt     = page_last_r;
    fill_value_nxt    = fill_value_r;
    clipped_width_nxt = clipped_width_r;
    byte_in_row_nxt   = byte_in_row_r;
    rows_left_nxt     = rows_left_r;
    res_valid         = 1'b0;
    res               = '0;
    if (step_en) begin
      if (step_item.operation == OP_START) begin
        if (!in_panel) begin
          phase_nxt = PH_IDLE;
        end else begin
          column_first_nxt  = step_item.x_start;
          column_last_nxt   = step_item.x_start + w_clip - 16'd1;
          page_first_nxt    = step_item.y_start;
          page_last_nxt     = step_item.y_start + h_clip - 16'd1;
          fill_value_nxt    = step_item.color;
          clipped_width_nxt = CW_W'(w_clip);
          rows_left_nxt     = RW_W'(h_clip);
          byte_in_row_nxt   = '0;
          phase_nxt         = PH_COL_CMD;
        end
      end else begin
        res_valid = 1'b1;
        phase_nxt = phase_t'(phase_r + 4'd1);
        unique case (phase_r)
          PH_IDLE: begin
            res_valid = 1'b0;
            phase_nxt = PH_IDLE;
          end
          PH_COL_CMD:  res = '{CMD_COLUMN_SET, 1'b0, 1'b1, 1'b0};
          PH_COL_SH:   res = '{column_first_r[15:8], 1'b1, 1'b0, 1'b0};
          PH_COL_SL:   res = '{column_first_r[7:0], 1'b1, 1'b0, 1'b0};
          PH_COL_EH:   res = '{column_last_r[15:8], 1'b1, 1'b0, 1'b0};
          PH_COL_EL:   res = '{column_last_r[7:0], 1'b1, 1'b1, 1'b0};
          PH_PAGE_CMD: res = '{CMD_PAGE_SET, 1'b0, 1'b1, 1'b0};
          PH_PAGE_SH:  res = '{page_first_r[15:8], 1'b1, 1'b0, 1'b0};
          PH_PAGE_SL:  res = '{page_first_r[7:0], 1'b1, 1'b0, 1'b0};
          PH_PAGE_EH:  res = '{page_last_r[15:8], 1'b1, 1'b0, 1'b0};
          PH_PAGE_EL:  res = '{page_last_r[7:0], 1'b1, 1'b1, 1'b0};
          PH_MEM_WR: begin
            res             = '{CMD_MEM_WRITE, 1'b0, 1'b1, empty};
            phase_nxt       = empty ? PH_IDLE : PH_PIXELS;
            byte_in_row_nxt = '0;
          end
          PH_PIXELS: begin
            phase_nxt = PH_PIXELS;
            if (row_end) begin
              rows_left_nxt   = rows_dec;
              byte_in_row_nxt = '0;
              res             = '{pix_byte, 1'b1, 1'b1, (rows_dec == '0)};
              if (rows_dec == '0) begin
                phase_nxt = PH_IDLE;
              end
            end else begin
              byte_in_row_nxt = byte_in_row_r + BR_W'(1);
              res             = '{pix_byte, 1'b1, 1'b0, 1'b0};
            end
          end
          default: begin
            res_valid = 1'b0;
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      column_first_r  <= '0;
      column_last_r   <= '0;
      page_first_r    <= '0;
      page_last_r     <= '0;
      fill_value_r    <= '0;
      clipped_width_r <= '0;
      byte_in_row_r   <= '0;
      rows_left_r     <= '0;
    end else begin
      phase_r         <= phase_nxt;
      column_first_r  <= column_first_nxt;
      column_last_r   <= column_last_nxt;
      page_first_r    <= page_first_nxt;
      page_last_r     <= page_last_nxt;
      fill_value_r    <= fill_value_nxt;
      clipped_width_r <= clipped_width_nxt;
      byte_in_row_r   <= byte_in_row_nxt;
      rows_left_r     <= rows_left_nxt;
    end
  end

endmodule

>>> hdl/lcd_window_rect_fill_sequencer_core.sv
// top level of the lcd window rectangle fill sequencer
// depends on lwrf_pkg and lwrf_seq
//
// in_*  channel: valid/ready transactions of lwrf_in_t. operation OP_START
//   loads a rectangle and color (clipped to the panel, dropped when the left
//   column or top row is off the panel) and yields no output. OP_ADVANCE asks
//   for the next serial byte of the command; advance while idle yields nothing.
// out_* channel: valid/ready transactions of lwrf_out_t, one per advance while
//   a command is active: column-set, four address bytes, page-set, four address
//   bytes, memory-write, then the color bytes row by row, high byte first.
//   last marks the final byte.
// timing: one input transaction per cycle sustained while the receiver does not stall;
//   a result appears on out_* in the cycle after its advance is taken, from one pass of clip /
//   byte-select logic between the sequencer state and the output register.
// stall: in_ready follows out_ready while a result is held, so a stalled
//   receiver holds the result in place and pauses the input side without loss.
// reset: synchronous active-low rst_n returns the sequencer to idle and
//   empties the output register.

module lcd_window_rect_fill_sequencer_core #(
  parameter int PANEL_WIDTH  = 320,
  parameter int PANEL_HEIGHT = 240
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  lwrf_pkg::lwrf_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lwrf_pkg::lwrf_out_t out_data
);
  import lwrf_pkg::*;

  logic      in_accept;
  logic      res_valid;
  lwrf_out_t res;
  logic      out_valid_r, out_valid_nxt;
  lwrf_out_t out_r;

  // output register is free when empty or being drained this cycle
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  lwrf_seq #(
    .PANEL_WIDTH (PANEL_WIDTH),
    .PANEL_HEIGHT(PANEL_HEIGHT)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_accept),
    .step_item(in_data),
    .res_valid(res_valid),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_accept) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload register, loaded only with a fresh result
  always_ff @(posedge clk) begin
    if (in_accept && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a start transaction never leaves a result behind
  a_start_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_data.operation == OP_START)) |=> !out_valid_r)
    else $error("result after start transaction");

  // command bytes always release select
  a_cmd_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.is_data) |-> out_r.release_select)
    else $error("command byte without select release");

  // the final byte always releases select
  a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.last) |-> out_r.release_select)
    else $error("last byte without select release");

  // an empty output register never blocks the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty output register");

endmodule

>>> bench/tb_lcd_window_rect_fill_sequencer_core.sv
// self-checking testbench for lcd_window_rect_fill_sequencer_core
// depends on lwrf_pkg and the sequencer rtl; builds its own byte predictor

module tb_lcd_window_rect_fill_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lwrf_pkg::*;

  localparam int PANEL_W      = 320;
  localparam int PANEL_H      = 240;
  // cycles with no transaction on either side before the run is called hung
  localparam int HANG_LIMIT   = 5000;
  // random transactions per idling phase, four phases in all
  localparam int PHASE_QUOTA  = 180;
  // spare cycles waited after the last expected byte
  localparam int DRAIN_CYCLES = 16;

  // one directed stimulus row: a transaction and, where it is obvious,
  // the byte it must produce; other rows fall back on the predictor
  typedef struct {
    lwrf_in_t  item;
    bit        typed;
    bit        want;
    lwrf_out_t res;
  } plan_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  lwrf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  lwrf_out_t out_data;

  // predictor copy of the sequencer state
  phase_t      seq_phase = PH_IDLE;
  logic [15:0] col_first = '0;
  logic [15:0] col_last = '0;
  logic [15:0] row_first = '0;
  logic [15:0] row_last = '0;
  logic [15:0] fill_color = '0;
  logic [8:0]  span_px = '0;
  logic [9:0]  byte_pos = '0;
  logic [8:0]  rows_todo = '0;

  lwrf_out_t   pending_bytes[$];
  plan_row_t   directed_rows[$];
  int          mismatches = 0;
  int          tally = 0;
  bit          tally_on = 1'b1;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  lcd_window_rect_fill_sequencer_core #(
    .PANEL_WIDTH (PANEL_W),
    .PANEL_HEIGHT(PANEL_H)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // byte predictor: advances the window state by one accepted transaction
  // and says whether a serial byte comes out and which
  // ---------------------------------------------------------------------
  task automatic window_step(input lwrf_in_t it, output bit produced,
                             output lwrf_out_t b);
    int unsigned xs;
    int unsigned ys;
    int unsigned ws;
    int unsigned hs;
    bit          empty;
    bit          row_end;
    produced = 1'b0;
    b = '0;
    if (it.operation == OP_START) begin
      xs = it.x_start;
      ys = it.y_start;
      ws = it.rect_width;
      hs = it.rect_height;
      // left column or top row off the panel: command dropped
      if (xs >= PANEL_W || ys >= PANEL_H) begin
        seq_phase = PH_IDLE;
      end else begin
        if (xs + ws > PANEL_W) ws = PANEL_W - xs;
        if (ys + hs > PANEL_H) hs = PANEL_H - ys;
        col_first  = 16'(xs);
        col_last   = 16'(xs + ws - 1);  // zero size wraps to start - 1
        row_first  = 16'(ys);
        row_last   = 16'(ys + hs - 1);
        fill_color = it.color;
        span_px    = 9'(ws);
        rows_todo  = 9'(hs);
        byte_pos   = '0;
        seq_phase  = PH_COL_CMD;
      end
      return;
    end
    produced = 1'b1;
    case (seq_phase)
      PH_COL_CMD:  b = '{CMD_COLUMN_SET, 1'b0, 1'b1, 1'b0};
      PH_COL_SH:   b = '{col_first[15:8], 1'b1, 1'b0, 1'b0};
      PH_COL_SL:   b = '{col_first[7:0], 1'b1, 1'b0, 1'b0};
      PH_COL_EH:   b = '{col_last[15:8], 1'b1, 1'b0, 1'b0};
      PH_COL_EL:   b = '{col_last[7:0], 1'b1, 1'b1, 1'b0};
      PH_PAGE_CMD: b = '{CMD_PAGE_SET, 1'b0, 1'b1, 1'b0};
      PH_PAGE_SH:  b = '{row_first[15:8], 1'b1, 1'b0, 1'b0};
      PH_PAGE_SL:  b = '{row_first[7:0], 1'b1, 1'b0, 1'b0};
      PH_PAGE_EH:  b = '{row_last[15:8], 1'b1, 1'b0, 1'b0};
      PH_PAGE_EL:  b = '{row_last[7:0], 1'b1, 1'b1, 1'b0};
      PH_MEM_WR: begin
        // empty window: memory-write closes the command
        empty = (span_px == 0) || (rows_todo == 0);
        b = '{CMD_MEM_WRITE, 1'b0, 1'b1, empty};
        seq_phase = empty ? PH_IDLE : PH_PIXELS;
        byte_pos = '0;
        return;
      end
      PH_PIXELS: begin
        b.spi_byte = byte_pos[0] ? fill_color[7:0] : fill_color[15:8];
        b.is_data = 1'b1;
        row_end = (int'(byte_pos) + 1 >= 2 * int'(span_px));
        if (row_end) begin
          rows_todo = (rows_todo == 0) ? 9'd0 : rows_todo - 9'd1;
          byte_pos = '0;
          b.release_select = 1'b1;
          if (rows_todo == 0) begin
            b.last = 1'b1;
            seq_phase = PH_IDLE;
          end
        end else begin
          byte_pos = byte_pos + 10'd1;
        end
        return;
      end
      default: begin
        // advance while idle: nothing comes out
        produced = 1'b0;
        seq_phase = PH_IDLE;
        return;
      end
    endcase
    seq_phase = phase_t'(seq_phase + 4'd1);
  endtask

  // ---------------------------------------------------------------------
  // transaction builders
  // ---------------------------------------------------------------------
  function automatic lwrf_in_t start_item(input int x, input int y, input int w,
                                          input int h, input int c);
    lwrf_in_t it;
    it.operation   = OP_START;
    it.x_start     = 16'(x);
    it.y_start     = 16'(y);
    it.rect_width  = 16'(w);
    it.rect_height = 16'(h);
    it.color       = 16'(c);
    return it;
  endfunction

  // advance carries random junk in the unused fields
  function automatic lwrf_in_t adv_item();
    lwrf_in_t it;
    it = start_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.operation = OP_ADVANCE;
    return it;
  endfunction

  function automatic lwrf_in_t noise_item();
    lwrf_in_t it;
    it = start_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.operation = op_t'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic plan_row_t quiet(input lwrf_in_t it);
    return '{it, 1'b1, 1'b0, '0};
  endfunction

  function automatic plan_row_t byte_row(input lwrf_in_t it, input logic [7:0] sb,
                                         input logic d, input logic rel,
                                         input logic lst);
    return '{it, 1'b1, 1'b1, '{sb, d, rel, lst}};
  endfunction

  function automatic plan_row_t free_row(input lwrf_in_t it);
    return '{it, 1'b0, 1'b0, '0};
  endfunction

  // ---------------------------------------------------------------------
  // input side: drive one transaction, hold it until taken, then predict
  // ---------------------------------------------------------------------
  task automatic send(input lwrf_in_t it, input bit typed = 1'b0,
                      input bit want = 1'b0, input lwrf_out_t res = '0);
    bit        produced;
    lwrf_out_t b;
    // random sender gaps; valid drops only on a gap, never between back-to-back items
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    // stray advances while idle do not count toward the quota
    if (tally_on && !(it.operation == OP_ADVANCE && seq_phase == PH_IDLE))
      tally++;
    window_step(it, produced, b);
    if (typed) begin
      if (want) pending_bytes.push_back(res);
    end else if (produced) begin
      pending_bytes.push_back(b);
    end
  endtask

  // ---------------------------------------------------------------------
  // random sequences, mostly complete rectangle commands
  // ---------------------------------------------------------------------
  task automatic random_sequence();
    int kind;
    int n;
    int x;
    int y;
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // well-formed command run to its last byte
      if ($urandom_range(0, 4) == 0) begin
        // near the corner with a huge size: clipped to a few pixels
        x = PANEL_W - $urandom_range(1, 3);
        y = PANEL_H - $urandom_range(1, 3);
        send(start_item(x, y, $urandom, $urandom, $urandom));
      end else begin
        x = $urandom_range(0, PANEL_W - 1);
        y = $urandom_range(0, PANEL_H - 1);
        send(start_item(x, y, $urandom_range(0, 4), $urandom_range(0, 3), $urandom));
      end
      while (seq_phase != PH_IDLE) send(adv_item());
      if ($urandom_range(0, 3) == 0) send(adv_item());
    end else if (kind < 72) begin
      // cut short, the next start takes over
      x = $urandom_range(0, PANEL_W - 1);
      y = $urandom_range(0, PANEL_H - 1);
      send(start_item(x, y, $urandom_range(1, 6), $urandom_range(1, 4), $urandom));
      n = $urandom_range(0, 24);
      repeat (n) send(adv_item());
    end else if (kind < 82) begin
      // off the panel in x or y: dropped
      if ($urandom_range(0, 1) == 0)
        send(start_item($urandom_range(PANEL_W, 65535), $urandom, $urandom, $urandom,
                        $urandom));
      else
        send(start_item($urandom_range(0, PANEL_W - 1), $urandom_range(PANEL_H, 65535),
                        $urandom, $urandom, $urandom));
      n = $urandom_range(0, 2);
      repeat (n) send(adv_item());
    end else if (kind < 86) begin
      // full-panel fill, only its opening is walked
      send(start_item(0, 0, 16'hFFFF, 16'hFFFF, $urandom));
      n = $urandom_range(0, 40);
      repeat (n) send(adv_item());
    end else begin
      n = $urandom_range(1, 6);
      repeat (n) send(noise_item());
    end
  endtask

  // one long rectangle run to the end, kept out of the quota
  task automatic long_strip(input bit wide);
    tally_on = 1'b0;
    if (wide)
      send(start_item(0, $urandom_range(0, PANEL_H - 1), 16'hFFFF, 1, $urandom));
    else
      send(start_item($urandom_range(0, PANEL_W - 1), 0, 1, 16'hFFFF, $urandom));
    while (seq_phase != PH_IDLE) send(adv_item());
    tally_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------
  // result side: random stalls and the byte check
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_bytes
    lwrf_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_bytes.size() == 0) begin
        $error("serial byte %02h arrived with nothing expected", out_data.spi_byte);
        mismatches++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_data.spi_byte !== want.spi_byte) begin
          $error("spi_byte: expected %02h, got %02h", want.spi_byte, out_data.spi_byte);
          mismatches++;
        end
        if (out_data.is_data !== want.is_data) begin
          $error("is_data: expected %0b, got %0b", want.is_data, out_data.is_data);
          mismatches++;
        end
        if (out_data.release_select !== want.release_select) begin
          $error("release_select: expected %0b, got %0b", want.release_select,
                 out_data.release_select);
          mismatches++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          mismatches++;
        end
      end
    end
  end

  // hang watchdog: resets on any transaction on either channel
  initial begin : hang_watch
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("lcd_window_rect_fill_sequencer_core: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------
  // main flow: reset, directed table, four idling phases, drain
  // ---------------------------------------------------------------------
  initial begin
    directed_rows = '{
      quiet(adv_item()),                                  // advance while idle
      quiet(start_item(0, 0, 1, 1, 16'hFFFF)),            // single pixel at origin
      byte_row(adv_item(), CMD_COLUMN_SET, 1'b0, 1'b1, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b1, 1'b0),
      byte_row(adv_item(), CMD_PAGE_SET, 1'b0, 1'b1, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'h00, 1'b1, 1'b1, 1'b0),
      byte_row(adv_item(), CMD_MEM_WRITE, 1'b0, 1'b1, 1'b0),
      byte_row(adv_item(), 8'hFF, 1'b1, 1'b0, 1'b0),
      byte_row(adv_item(), 8'hFF, 1'b1, 1'b1, 1'b1),
      // all fields at their maximum: off the panel, dropped
      quiet(start_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF)),
      quiet(adv_item()),
      // bottom-right pixel with huge size, clipped to one pixel
      quiet(start_item(PANEL_W - 1, PANEL_H - 1, 16'hFFFF, 16'hFFFF, 16'hA55A)),
      free_row(adv_item()),
      free_row(adv_item()),
      // zero width replaces the command in progress; end column wraps
      quiet(start_item(0, 0, 0, 3, 16'h0000)),
      free_row(adv_item()),
      free_row(adv_item()),
      free_row(adv_item()),
      free_row(adv_item())
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want,
           directed_rows[i].res);

    for (int m = 0; m < 4; m++) begin
      case (m)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
        end
      endcase
      // a full-width row, once
      if (m == 0) long_strip(1'b1);
      while (tally < (m + 1) * PHASE_QUOTA) random_sequence();
    end
    in_valid <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("lcd_window_rect_fill_sequencer_core: match");
    end else begin
      $display("lcd_window_rect_fill_sequencer_core: mismatch");
    end
    $finish;
  end

endmodule
